>>> rtl/core/ckap_pkg.sv
// Shared types and constants for the chroma key alpha pipeline.
// No dependencies; imported by color_key_alpha_pixel.
package ckap_pkg;

    localparam int CHANNELS  = 3;
    localparam int STAGES    = 8;
    localparam int REM_W     = 16;
    localparam int SUM_W     = 10;
    localparam int ADDR_W    = 5;

    localparam logic [7:0]       ALPHA_OPAQUE = 8'd255;
    localparam logic [SUM_W-1:0] THIRD_MUL    = 10'd683;
    localparam int               THIRD_SHIFT  = 11;

    localparam logic [7:0] KEY_RESET = 8'd0;
    localparam logic [7:0] TOL_RESET = 8'd64;

    typedef enum logic [2:0] {
        REG_KEY_RED   = 3'd0,
        REG_KEY_GREEN = 3'd1,
        REG_KEY_BLUE  = 3'd2,
        REG_TOL_RED   = 3'd3,
        REG_TOL_GREEN = 3'd4,
        REG_TOL_BLUE  = 3'd5,
        REG_NONE_6    = 3'd6,
        REG_NONE_7    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [CHANNELS-1:0][7:0]       color;
        logic [CHANNELS-1:0]            in_key;
        logic [CHANNELS-1:0][REM_W-1:0] rem;
        logic [CHANNELS-1:0][7:0]       quo;
        logic [SUM_W-1:0]               sum;
        logic [7:0]                     alpha;
    } pix_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic             hit;
    } div_t;

    // One restoring division step: subtract the shifted divisor where it fits.
    function automatic div_t div_step(input logic [REM_W-1:0] rem,
                                      input logic [7:0] tol,
                                      input logic [2:0] idx);
        logic [REM_W-1:0] sub;
        div_t             res;
        begin
            sub = REM_W'(tol) << idx;
            res.hit = (rem >= sub);
            res.rem = res.hit ? (rem - sub) : rem;
            return res;
        end
    endfunction

endpackage

>>> rtl/core/color_key_alpha_pixel.sv
// Chroma key alpha pipeline: per-channel distance, pipelined divide, averaging.
// Depends on ckap_pkg.
//
//  channel | dir | handshake             | payload
//  s_*     | in  | s_tvalid / s_tready   | s_tdata  pixel_red, pixel_green, pixel_blue
//  m_*     | out | m_tvalid / m_tready   | m_tdata  out_red, out_green, out_blue, out_alpha
//  apb     | in  | psel, penable, pwrite | paddr, pwdata, prdata, pready
//
// The datapath has eight register stages: distance, scale by 255,
// four radix-4 divide stages, channel sum, and the divide by three.
// One request is taken every cycle while the output side keeps up.
// Each stage holds only when it is full and the stage after it holds, so
// bubbles close up under backpressure. Reset empties the pipeline and loads
// keys of 0 and tolerances of 64.
module color_key_alpha_pixel
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [23:0]                s_tdata,  // pixel_red, pixel_green, pixel_blue
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,  // out_red, out_green, out_blue, out_alpha
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ckap_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import ckap_pkg::*;

    logic [CHANNELS-1:0][7:0] key_reg;
    logic [CHANNELS-1:0][7:0] tol_reg;
    logic [7:0]               held_tol;
    reg_idx_t                 reg_idx;
    logic                     cfg_write;

    pix_t                     pipe_reg   [STAGES];
    pix_t                     stage_next [STAGES];
    logic [STAGES-1:0]        valid_reg;
    logic [STAGES-1:0]        valid_in;
    logic [STAGES-1:0]        ready;

    logic [CHANNELS-1:0][7:0] chan_dist;
    logic [CHANNELS-1:0][7:0] diff;
    div_t                     step_hi;
    div_t                     step_lo;
    logic [2:0]               bit_hi;
    logic [2:0]               bit_lo;
    logic [2*SUM_W-1:0]       third_prod;
    logic [8:0]               third;

    // configuration port
    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite && pready;
    assign held_tol  = (pwdata[7:0] == 8'd0) ? 8'd1 : pwdata[7:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= {CHANNELS{KEY_RESET}};
            tol_reg <= {CHANNELS{TOL_RESET}};
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_KEY_RED:   key_reg[0] <= pwdata[7:0];
                REG_KEY_GREEN: key_reg[1] <= pwdata[7:0];
                REG_KEY_BLUE:  key_reg[2] <= pwdata[7:0];
                REG_TOL_RED:   tol_reg[0] <= held_tol;
                REG_TOL_GREEN: tol_reg[1] <= held_tol;
                REG_TOL_BLUE:  tol_reg[2] <= held_tol;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_KEY_RED:   prdata = {24'd0, key_reg[0]};
            REG_KEY_GREEN: prdata = {24'd0, key_reg[1]};
            REG_KEY_BLUE:  prdata = {24'd0, key_reg[2]};
            REG_TOL_RED:   prdata = {24'd0, tol_reg[0]};
            REG_TOL_GREEN: prdata = {24'd0, tol_reg[1]};
            REG_TOL_BLUE:  prdata = {24'd0, tol_reg[2]};
            default:       prdata = 32'd0;
        endcase
    end

    // stage flow control
    always_comb
    begin
        ready[STAGES-1] = !valid_reg[STAGES-1] || m_tready;
        for (int k = STAGES-2; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
        valid_in[0] = s_tvalid;
        for (int k = 1; k < STAGES; k++)
        begin
            valid_in[k] = valid_reg[k-1];
        end
    end

    assign s_tready = ready[0];

    // stage datapath
    always_comb
    begin
        for (int k = 0; k < STAGES; k++)
        begin
            stage_next[k] = (k == 0) ? pipe_reg[0] : pipe_reg[k-1];
        end

        // distance and inside test
        for (int c = 0; c < CHANNELS; c++)
        begin
            stage_next[0].color[c] = s_tdata[8*c +: 8];
            chan_dist[c] = (s_tdata[8*c +: 8] >= key_reg[c]) ?
                           (s_tdata[8*c +: 8] - key_reg[c]) : (key_reg[c] - s_tdata[8*c +: 8]);
            diff[c] = tol_reg[c] - chan_dist[c];
            stage_next[0].in_key[c] = (chan_dist[c] < tol_reg[c]);
            stage_next[0].rem[c]    = REM_W'(diff[c]);
            stage_next[0].quo[c]    = 8'd0;
        end
        stage_next[0].sum   = '0;
        stage_next[0].alpha = '0;

        // scale by 255
        for (int c = 0; c < CHANNELS; c++)
        begin
            stage_next[1].rem[c] = (pipe_reg[0].rem[c] << 8) - pipe_reg[0].rem[c];
        end

        // divide by tolerance, two quotient bits per stage
        step_hi = '0;
        step_lo = '0;
        bit_hi  = '0;
        bit_lo  = '0;
        for (int s = 2; s < 6; s++)
        begin
            bit_hi = 3'(2*(5-s)+1);
            bit_lo = 3'(2*(5-s));
            for (int c = 0; c < CHANNELS; c++)
            begin
                step_hi = div_step(pipe_reg[s-1].rem[c], tol_reg[c], bit_hi);
                step_lo = div_step(step_hi.rem, tol_reg[c], bit_lo);
                stage_next[s].rem[c]         = step_lo.rem;
                stage_next[s].quo[c][bit_hi] = step_hi.hit;
                stage_next[s].quo[c][bit_lo] = step_lo.hit;
            end
        end

        // channel sum
        stage_next[6].sum = SUM_W'(pipe_reg[5].quo[0]) + SUM_W'(pipe_reg[5].quo[1])
                          + SUM_W'(pipe_reg[5].quo[2]);

        // divide by three and form alpha
        third_prod = (2*SUM_W)'(pipe_reg[6].sum) * (2*SUM_W)'(THIRD_MUL);
        third      = third_prod[THIRD_SHIFT +: 9];
        stage_next[7].alpha = (&pipe_reg[6].in_key) ?
                              8'(9'(ALPHA_OPAQUE) - third) : ALPHA_OPAQUE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                if (ready[k])
                begin
                    valid_reg[k] <= valid_in[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < STAGES; k++)
        begin
            if (ready[k] && valid_in[k])
            begin
                pipe_reg[k] <= stage_next[k];
            end
        end
    end

    assign m_tvalid = valid_reg[STAGES-1];
    assign m_tdata  = {pipe_reg[STAGES-1].alpha, pipe_reg[STAGES-1].color[2],
                       pipe_reg[STAGES-1].color[1], pipe_reg[STAGES-1].color[0]};

`ifndef NO_ASSERTIONS
    a_outside_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !(&pipe_reg[STAGES-1].in_key)) |-> (m_tdata[31:24] == ALPHA_OPAQUE))
        else $error("pixel outside key not opaque");

    a_ready_with_room: assert property (@(posedge clk) disable iff (!rst_n)
        !(&valid_reg) |-> s_tready)
        else $error("input held while pipeline has an empty stage");

    a_tol_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (tol_reg[0] != 8'd0) && (tol_reg[1] != 8'd0) && (tol_reg[2] != 8'd0))
        else $error("tolerance register holds zero");

    a_remainder_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[5] && (&pipe_reg[5].in_key))
                    |-> ((pipe_reg[5].rem[0] < 16'(tol_reg[0]))
                      && (pipe_reg[5].rem[1] < 16'(tol_reg[1]))
                      && (pipe_reg[5].rem[2] < 16'(tol_reg[2]))))
        else $error("division remainder not below tolerance");
`endif

endmodule
